// File: rtl/kplps_pkg.sv
// ----------------------------------------------------------------------------
// kplps_pkg
// Shared types and constants of the key scanner with long-press detection.
// ----------------------------------------------------------------------------
package kplps_pkg;

   localparam int NUM_KEYS  = 8;
   localparam int KEY_SLOTS = 8;
   localparam int KEYS_USED = (NUM_KEYS < KEY_SLOTS) ? NUM_KEYS : KEY_SLOTS;
   localparam int KEY_W     = (KEYS_USED > 1) ? $clog2(KEYS_USED) : 1;

   localparam int TICK_W   = 15;
   localparam int PERIOD_W = 10;
   localparam int LPT_W    = 24;
   localparam int PROD_W   = TICK_W + PERIOD_W;
   localparam int ENTRY_W  = TICK_W + 1;

   localparam logic [KEY_SLOTS-1:0] USED_MASK  = KEY_SLOTS'((1 << KEYS_USED) - 1);
   localparam logic [KEY_W-1:0]     LAST_KEY   = KEY_W'(KEYS_USED - 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ACTIVE_LEVELS   = 2'd0;
   localparam logic [1:0] REG_TICK_PERIOD     = 2'd1;
   localparam logic [1:0] REG_LONG_PRESS_TIME = 2'd2;

   localparam logic [KEY_SLOTS-1:0] ACTIVE_RESET = '0;
   localparam logic [PERIOD_W-1:0]  PERIOD_RESET = PERIOD_W'(1);
   localparam logic [LPT_W-1:0]     LPT_RESET    = LPT_W'(1000);

   typedef struct packed {
      logic [KEY_SLOTS-1:0] pin_levels;
      logic [TICK_W-1:0]    tick_now;
   } req_type;

   typedef struct packed {
      logic [KEY_SLOTS-1:0] pressed_mask;
      logic [KEY_SLOTS-1:0] event_mask;
      logic [KEY_SLOTS-1:0] long_mask;
      logic                 any_event;
   } rsp_type;

   // one scan as it walks the key pipeline
   typedef struct packed {
      logic [KEY_SLOTS-1:0] pressed;
      logic [KEY_SLOTS-1:0] events;
      logic [TICK_W-1:0]    tick;
   } scan_ctx_type;

endpackage

// File: rtl/kplps_ram.sv
// ----------------------------------------------------------------------------
// kplps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kplps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/key_press_long_press_scanner.sv
// ----------------------------------------------------------------------------
// key_press_long_press_scanner
// Key scanner: per-key press/release events and long-press detection.
// ----------------------------------------------------------------------------
//
//   channel  | ports                          | word
//   ---------+--------------------------------+---------------------------------
//   scan in  | req_valid req_ready req_data   | pin levels, tick count
//   result   | rsp_valid rsp_ready rsp_data   | pressed/event/long masks, any
//   config   | psel penable pwrite paddr ...  | 32-bit registers at 4*index
//
// A scan walks one key per cycle unless a write-back hazard holds it: the key
// state RAM has one read and one write port, and each key is read, updated and
// written back. Scans overlap. With one or two keys, a scan waits on the
// write-back of the same entry. Reset clears all state at once through per-key
// valid bits. A two-word result queue absorbs output stalls; at most two scans
// are open.
//
module key_press_long_press_scanner
   import kplps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration
   logic [KEY_SLOTS-1:0] active_ff, active_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [LPT_W-1:0]     lpt_ff, lpt_in;
   logic                 csr_wr;
   logic [1:0]           csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      active_in = active_ff;
      period_in = period_ff;
      lpt_in    = lpt_ff;
      prdata    = '0;
      case (csr_idx)
         REG_ACTIVE_LEVELS: begin
            prdata = CSR_DATA_W'(active_ff);
            if (csr_wr) active_in = pwdata[KEY_SLOTS-1:0];
         end
         REG_TICK_PERIOD: begin
            prdata = CSR_DATA_W'(period_ff);
            if (csr_wr) period_in = pwdata[PERIOD_W-1:0];
         end
         REG_LONG_PRESS_TIME: begin
            prdata = CSR_DATA_W'(lpt_ff);
            if (csr_wr) lpt_in = pwdata[LPT_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // issue stage: walk the keys of the current scan
   logic                 iss_valid_ff, iss_valid_in;
   logic [KEY_W-1:0]     iss_key_ff, iss_key_in;
   scan_ctx_type         iss_ctx_ff, iss_ctx_in;
   logic [KEY_SLOTS-1:0] prev_ff, prev_in;
   logic [1:0]           inflight_ff, inflight_in;
   logic [KEYS_USED-1:0] vld_ff, vld_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic [KEY_W-1:0]     s1_key_ff, s1_key_in;
   scan_ctx_type         s1_ctx_ff, s1_ctx_in;
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_last_ff, s1_last_in;

   logic                 s2_valid_ff, s2_valid_in;
   logic [KEY_W-1:0]     s2_key_ff, s2_key_in;
   scan_ctx_type         s2_ctx_ff, s2_ctx_in;
   logic                 s2_flag_ff, s2_flag_in;
   logic [TICK_W-1:0]    s2_ts_ff, s2_ts_in;
   logic [PROD_W-1:0]    s2_prod_ff, s2_prod_in;
   logic                 s2_last_ff, s2_last_in;

   logic                 hazard, issue, iss_last, accept, pop;
   logic [KEY_SLOTS-1:0] pressed_now;

   // hold issue while an older access to the same entry is not yet written
   assign hazard = (s1_valid_ff && (s1_key_ff == iss_key_ff)) ||
                   (s2_valid_ff && (s2_key_ff == iss_key_ff));
   assign issue     = iss_valid_ff && !hazard;
   assign iss_last  = (iss_key_ff == LAST_KEY);
   assign req_ready = (!iss_valid_ff || (issue && iss_last)) && (inflight_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   assign pressed_now = ~(req_data.pin_levels ^ active_ff) & USED_MASK;

   always_comb begin
      iss_valid_in = iss_valid_ff;
      iss_key_in   = iss_key_ff;
      iss_ctx_in   = iss_ctx_ff;
      prev_in      = prev_ff;
      if (issue) begin
         iss_key_in = iss_key_ff + KEY_W'(1);
         if (iss_last) iss_valid_in = 1'b0;
      end
      if (accept) begin
         iss_valid_in       = 1'b1;
         iss_key_in         = '0;
         iss_ctx_in.pressed = pressed_now;
         iss_ctx_in.events  = pressed_now ^ prev_ff;
         iss_ctx_in.tick    = req_data.tick_now;
         prev_in            = pressed_now;
      end
      inflight_in = inflight_ff + 2'(accept) - 2'(pop);
   end

   // key state RAM: {long flag, press timestamp}
   logic                 wr_en;
   logic [ENTRY_W-1:0]   wr_data, rd_data;

   kplps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEYS_USED)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_key_ff),
      .wr_data (wr_data),
      .rd_addr (iss_key_ff),
      .rd_data (rd_data)
   );

   // stage 1: entry arrives, form elapsed ticks times period
   logic [ENTRY_W-1:0] s1_entry;
   logic [TICK_W-1:0]  s1_elapsed;

   assign s1_valid_in = issue;
   assign s1_key_in   = iss_key_ff;
   assign s1_ctx_in   = iss_ctx_ff;
   assign s1_vld_in   = vld_ff[iss_key_ff];
   assign s1_last_in  = iss_last;

   // a never-written entry reads as the reset value
   assign s1_entry   = s1_vld_ff ? rd_data : '0;
   assign s1_elapsed = s1_ctx_ff.tick - s1_entry[TICK_W-1:0];

   assign s2_valid_in = s1_valid_ff;
   assign s2_key_in   = s1_key_ff;
   assign s2_ctx_in   = s1_ctx_ff;
   assign s2_flag_in  = s1_entry[ENTRY_W-1];
   assign s2_ts_in    = s1_entry[TICK_W-1:0];
   assign s2_prod_in  = PROD_W'(s1_elapsed) * PROD_W'(period_ff);
   assign s2_last_in  = s1_last_ff;

   // stage 2: compare, write back, collect masks
   logic                 ev_b, pr_b, hit, new_flag;
   logic [TICK_W-1:0]    new_ts;
   logic [KEY_SLOTS-1:0] key_bit;
   logic [KEY_SLOTS-1:0] evt_acc_ff, evt_acc_in, long_acc_ff, long_acc_in;
   logic                 push;
   rsp_type              push_data;

   assign ev_b     = s2_ctx_ff.events[s2_key_ff];
   assign pr_b     = s2_ctx_ff.pressed[s2_key_ff];
   assign hit      = !ev_b && pr_b && !s2_flag_ff && (s2_prod_ff >= PROD_W'(lpt_ff));
   assign new_flag = ev_b ? 1'b0 : (s2_flag_ff || hit);
   assign new_ts   = ev_b ? s2_ctx_ff.tick : s2_ts_ff;
   assign key_bit  = KEY_SLOTS'(1) << s2_key_ff;

   assign wr_en   = s2_valid_ff;
   assign wr_data = {new_flag, new_ts};

   always_comb begin
      vld_in      = vld_ff;
      evt_acc_in  = evt_acc_ff;
      long_acc_in = long_acc_ff;
      if (s2_valid_ff) begin
         vld_in[s2_key_ff] = 1'b1;
         // restart the masks on the first key of a scan
         if (s2_key_ff == '0) begin
            evt_acc_in  = '0;
            long_acc_in = '0;
         end
         if (ev_b || hit) evt_acc_in  = evt_acc_in | key_bit;
         if (new_flag)    long_acc_in = long_acc_in | key_bit;
      end
   end

   assign push                   = s2_valid_ff && s2_last_ff;
   assign push_data.pressed_mask = s2_ctx_ff.pressed;
   assign push_data.event_mask   = evt_acc_in;
   assign push_data.long_mask    = long_acc_in;
   assign push_data.any_event    = |evt_acc_in;

   // two-word result queue
   rsp_type    q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0] qcnt_ff, qcnt_in;

   always_comb begin
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      qcnt_in = qcnt_ff + 2'(push) - 2'(pop);
      if (pop) begin
         q0_in = q1_ff;
         if (push) begin
            if (qcnt_ff == 2'd1) q0_in = push_data;
            else                 q1_in = push_data;
         end
      end else if (push) begin
         if (qcnt_ff == 2'd0) q0_in = push_data;
         else                 q1_in = push_data;
      end
   end

   assign rsp_valid = (qcnt_ff != 2'd0);
   assign rsp_data  = q0_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         period_ff    <= PERIOD_RESET;
         lpt_ff       <= LPT_RESET;
         iss_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         prev_ff      <= '0;
         inflight_ff  <= '0;
         vld_ff       <= '0;
         qcnt_ff      <= '0;
      end else begin
         active_ff    <= active_in;
         period_ff    <= period_in;
         lpt_ff       <= lpt_in;
         iss_valid_ff <= iss_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         prev_ff      <= prev_in;
         inflight_ff  <= inflight_in;
         vld_ff       <= vld_in;
         qcnt_ff      <= qcnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      iss_key_ff  <= iss_key_in;
      iss_ctx_ff  <= iss_ctx_in;
      s1_key_ff   <= s1_key_in;
      s1_ctx_ff   <= s1_ctx_in;
      s1_vld_ff   <= s1_vld_in;
      s1_last_ff  <= s1_last_in;
      s2_key_ff   <= s2_key_in;
      s2_ctx_ff   <= s2_ctx_in;
      s2_flag_ff  <= s2_flag_in;
      s2_ts_ff    <= s2_ts_in;
      s2_prod_ff  <= s2_prod_in;
      s2_last_ff  <= s2_last_in;
      evt_acc_ff  <= evt_acc_in;
      long_acc_ff <= long_acc_in;
      q0_ff       <= q0_in;
      q1_ff       <= q1_in;
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key scanner with long-press detection.
// A table of directed scans and register writes runs first, then seven
// random phases with different register settings. Every accepted scan is
// run through a local copy of the key state to predict its result word, and
// result words are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   import kplps_pkg::*;

   localparam int CYCLE_LIMIT     = 800000;
   localparam int PHASES          = 7;
   localparam int SCANS_PER_PHASE = 200;
   localparam int DRAIN_CYCLES    = 3 * KEYS_USED + 8;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum logic {ROW_SCAN, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   idx;
      logic [31:0]  value;
      req_type      scan;
      bit           typed;
      rsp_type      want;
   } step_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // register copies and key state of the predictor
   logic [KEY_SLOTS-1:0] cfg_active;
   logic [PERIOD_W-1:0]  cfg_period;
   logic [LPT_W-1:0]     cfg_long_time;
   logic [KEY_SLOTS-1:0] last_pressed;
   logic [TICK_W-1:0]    press_tick [KEY_SLOTS];
   logic                 long_held  [KEY_SLOTS];

   rsp_type      expected_scans[$];
   step_row_type plan[$];

   int          errors = 0;
   int          cycle_count = 0;
   bit          tx_gaps_on;
   bit          rx_stalls_on;
   int          hold_left = 0;
   int          stall_left = 0;
   logic [7:0]  cur_pins;
   logic [14:0] cur_tick;
   int unsigned th_ticks;

   key_press_long_press_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out", $time);
         $display("** key_press_long_press_scanner: FAILED **");
         $finish;
      end
   end

   function automatic int gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one scan through the key state; updates the state and returns the word
   function automatic rsp_type scan_keys(req_type w);
      rsp_type              r;
      logic [KEY_SLOTS-1:0] pressed;
      logic [KEY_SLOTS-1:0] events;
      logic [KEY_SLOTS-1:0] longs;
      logic [TICK_W-1:0]    elapsed;
      logic [31:0]          held;
      pressed = ~(w.pin_levels ^ cfg_active) & USED_MASK;
      events  = last_pressed ^ pressed;
      longs   = '0;
      for (int k = 0; k < KEYS_USED; k++) begin
         if (events[k]) begin
            press_tick[k] = w.tick_now;
            long_held[k]  = 1'b0;
         end else if (pressed[k] && !long_held[k]) begin
            elapsed = w.tick_now - press_tick[k];
            held    = 32'(elapsed) * 32'(cfg_period);
            if (held >= 32'(cfg_long_time)) begin
               long_held[k] = 1'b1;
               events[k]    = 1'b1;
            end
         end
         longs[k] = long_held[k];
      end
      last_pressed   = pressed;
      r.pressed_mask = pressed;
      r.event_mask   = events;
      r.long_mask    = longs;
      r.any_event    = |events;
      return r;
   endfunction

   // mostly held keys with occasional flips; a few scans are pure noise
   function automatic req_type next_scan();
      req_type     w;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         cur_pins = 8'($urandom);
         cur_tick = 15'($urandom);
      end else begin
         if (roll < 30)
            cur_pins = cur_pins ^ (8'd1 << $urandom_range(0, 7));
         else if (roll < 36)
            cur_pins = cur_pins ^ 8'($urandom);
         cur_tick = cur_tick + 15'($urandom_range(0, th_ticks / 3 + 1));
      end
      w.pin_levels = cur_pins;
      w.tick_now   = cur_tick;
      return w;
   endfunction

   task automatic send_scan(input req_type w, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = tx_gaps_on ? gap_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      predicted = scan_keys(w);
      expected_scans.push_back(typed ? want : predicted);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write a register, then read it back unless it is the unused index
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] want;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ACTIVE_LEVELS: begin
            cfg_active = value[KEY_SLOTS-1:0];
            want = 32'(cfg_active);
         end
         REG_TICK_PERIOD: begin
            cfg_period = value[PERIOD_W-1:0];
            want = 32'(cfg_period);
         end
         REG_LONG_PRESS_TIME: begin
            cfg_long_time = value[LPT_W-1:0];
            want = 32'(cfg_long_time);
         end
         default: want = '0;
      endcase
      if (idx != REG_UNUSED) begin
         @(negedge clock);
         penable = 1'b0;
         pwrite  = 1'b0;
         @(negedge clock);
         penable = 1'b1;
         do @(posedge clock); while (!pready);
         if (prdata !== want) begin
            errors++;
            $display("%0t: register %0d read back expected %h, got %h",
                     $time, idx, want, prdata);
         end
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic add_scan(input logic [7:0] pins, input logic [14:0] tick,
                           input bit typed, input rsp_type want);
      step_row_type row;
      row.kind  = ROW_SCAN;
      row.idx   = REG_UNUSED;
      row.value = '0;
      row.scan  = {pins, tick};
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endtask

   task automatic add_csr(input logic [1:0] idx, input logic [31:0] value);
      step_row_type row;
      row.kind  = ROW_CSR;
      row.idx   = idx;
      row.value = value;
      row.scan  = '0;
      row.typed = 1'b0;
      row.want  = '0;
      plan.push_back(row);
   endtask

   task automatic run_phase(input int ph);
      logic [31:0] act;
      logic [31:0] per;
      logic [31:0] lpt;
      act = $urandom_range(0, 255);
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      case (ph)
         0: begin per = 1; lpt = $urandom_range(0, 40); end
         1: begin act = 0; per = 1000; lpt = 32'hFF_FFFF; end
         2: begin
            act = 255;
            per = $urandom_range(1, 1000);
            lpt = $urandom_range(0, 200000);
            tx_gaps_on = 1'b0;
         end
         3: begin per = 0; lpt = 0; end
         4: begin
            per = 1023;
            lpt = $urandom_range(1000, 3000000);
            tx_gaps_on   = 1'b0;
            rx_stalls_on = 1'b0;
         end
         5: begin
            // junk in the unused upper bits must be dropped
            per = {22'($urandom_range(0, 32'h3F_FFFF)), 10'($urandom_range(1, 1000))};
            lpt = {8'($urandom), 24'($urandom)};
            act = {24'($urandom), 8'(act)};
         end
         default: begin per = 1; lpt = $urandom_range(20000, 32767); end
      endcase
      wait_idle();
      csr_write(REG_ACTIVE_LEVELS, act);
      csr_write(REG_TICK_PERIOD, per);
      csr_write(REG_LONG_PRESS_TIME, lpt);
      if (cfg_period == 0)
         th_ticks = 64;
      else
         th_ticks = 32'(cfg_long_time) / 32'(cfg_period);
      if (th_ticks > 32767) th_ticks = 32767;
      // hold the result side off so the block backs up into its input
      if (ph == 2) hold_left = 300;
      repeat (SCANS_PER_PHASE) send_scan(next_scan(), 1'b0, '0);
   endtask

   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      errors++;
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
   endtask

   // result side: random stalls and one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scans.size() == 0) begin
            errors++;
            $display("%0t: result word %h with nothing expected", $time, rsp_data);
         end else begin
            want = expected_scans.pop_front();
            if (rsp_data.pressed_mask !== want.pressed_mask)
               flag_field("pressed_mask", 32'(want.pressed_mask), 32'(rsp_data.pressed_mask));
            if (rsp_data.event_mask !== want.event_mask)
               flag_field("event_mask", 32'(want.event_mask), 32'(rsp_data.event_mask));
            if (rsp_data.long_mask !== want.long_mask)
               flag_field("long_mask", 32'(want.long_mask), 32'(rsp_data.long_mask));
            if (rsp_data.any_event !== want.any_event)
               flag_field("any_event", 32'(want.any_event), 32'(rsp_data.any_event));
         end
      end
   end

   initial begin
      step_row_type row;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      cfg_active    = ACTIVE_RESET;
      cfg_period    = PERIOD_RESET;
      cfg_long_time = LPT_RESET;
      last_pressed  = '0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
         press_tick[k] = '0;
         long_held[k]  = 1'b0;
      end
      cur_pins     = '0;
      cur_tick     = '0;
      th_ticks     = 1000;
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: pressed reads low, one unit per tick, threshold 1000
      add_scan(8'hFF, 15'd0,    1'b1, {8'h00, 8'h00, 8'h00, 1'b0});
      add_scan(8'h00, 15'd5,    1'b1, {8'hFF, 8'hFF, 8'h00, 1'b1});
      add_scan(8'h00, 15'd1004, 1'b1, {8'hFF, 8'h00, 8'h00, 1'b0});
      add_scan(8'h00, 15'd1005, 1'b1, {8'hFF, 8'hFF, 8'hFF, 1'b1});
      add_scan(8'h00, 15'd2000, 1'b1, {8'hFF, 8'h00, 8'hFF, 1'b0});
      add_scan(8'hFF, 15'd2001, 1'b1, {8'h00, 8'hFF, 8'h00, 1'b1});
      // hold across the tick wrap
      add_scan(8'h0F, 15'h7FFF, 1'b1, {8'hF0, 8'hF0, 8'h00, 1'b1});
      add_scan(8'h0F, 15'd998,  1'b1, {8'hF0, 8'h00, 8'h00, 1'b0});
      add_scan(8'h0F, 15'd999,  1'b1, {8'hF0, 8'hF0, 8'hF0, 1'b1});
      add_scan(8'hFF, 15'd1000, 1'b1, {8'h00, 8'hF0, 8'h00, 1'b1});
      // period 1000 and largest threshold, pressed reads high
      add_csr(REG_ACTIVE_LEVELS, 32'hFF);
      add_csr(REG_TICK_PERIOD, 32'd1000);
      add_csr(REG_LONG_PRESS_TIME, 32'hFF_FFFF);
      add_scan(8'hAA, 15'd0,     1'b1, {8'hAA, 8'hAA, 8'h00, 1'b1});
      add_scan(8'hAA, 15'd16777, 1'b1, {8'hAA, 8'h00, 8'h00, 1'b0});
      add_scan(8'hAA, 15'd16778, 1'b1, {8'hAA, 8'hAA, 8'hAA, 1'b1});
      add_scan(8'h55, 15'd16779, 1'b1, {8'h55, 8'hFF, 8'h00, 1'b1});
      // zero threshold: flag on the first scan still held
      add_csr(REG_LONG_PRESS_TIME, 32'd0);
      add_csr(REG_TICK_PERIOD, 32'h3FF);
      add_scan(8'h55, 15'd16779, 1'b1, {8'h55, 8'h55, 8'h55, 1'b1});
      add_scan(8'h00, 15'd3,     1'b1, {8'h00, 8'h55, 8'h00, 1'b1});
      // zero period: only a zero threshold can be reached
      add_csr(REG_TICK_PERIOD, 32'd0);
      add_scan(8'h0F, 15'd100,   1'b1, {8'h0F, 8'h0F, 8'h00, 1'b1});
      add_scan(8'h0F, 15'd30000, 1'b1, {8'h0F, 8'h0F, 8'h0F, 1'b1});
      add_csr(REG_LONG_PRESS_TIME, 32'd5);
      add_scan(8'hF0, 15'd200,   1'b1, {8'hF0, 8'hFF, 8'h00, 1'b1});
      add_scan(8'hF0, 15'd20000, 1'b1, {8'hF0, 8'h00, 8'h00, 1'b0});
      // write past the last register: must change nothing
      add_csr(REG_UNUSED, 32'hFFFF_FFFF);
      add_scan(8'hF0, 15'h7FFF,  1'b1, {8'hF0, 8'h00, 8'h00, 1'b0});
      add_scan(8'h3C, 15'd40,    1'b0, '0);
      add_scan(8'h3C, 15'd50,    1'b0, '0);

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            csr_write(row.idx, row.value);
         end else begin
            send_scan(row.scan, row.typed, row.want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) run_phase(ph);

      wait_idle();
      if (errors == 0)
         $display("** key_press_long_press_scanner: PASSED **");
      else
         $display("** key_press_long_press_scanner: FAILED **");
      $finish;
   end

endmodule
